FILE: design/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg : shared types and constants for the decimal ASCII formatter
// Digit chain sizing, character codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int IN_W       = 32;            // binary input width
  localparam int NUM_CELLS  = 10;            // BCD digits needed for IN_W bits
  localparam int MAX_DIGITS = 10;            // characters kept per request
  localparam int KEEP       = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
  localparam int BIT_CNT_W  = $clog2(IN_W);
  localparam int LEFT_W     = $clog2(NUM_CELLS + 1);
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // control for every cell of the chain, one cycle at a time
  typedef struct packed {
    logic clear;   // start a new conversion
    logic dabble;  // add-3 correction, then shift one binary bit in
    logic shift;   // take the lower neighbor's digit (move digits up)
  } cell_ctl_t;

endpackage

FILE: design/dcf_cell.sv
// ----------------------------------------------------------------------------
// dcf_cell : one BCD digit of the conversion chain
// Double-dabble step on its own digit, or hands digits upward for output.
// ----------------------------------------------------------------------------
module dcf_cell (
  input  logic                        clk,
  input  dcf_pkg::cell_ctl_t          ctl,
  input  logic                        bit_in,     // from lower cell or binary MSB
  input  logic [dcf_pkg::DIGIT_W-1:0] digit_in,   // lower cell's digit
  output logic [dcf_pkg::DIGIT_W-1:0] digit,
  output logic                        carry_out   // to upper cell
);

  logic [dcf_pkg::DIGIT_W-1:0] adj;

  // >= 5 gets +3 so the following shift carries correctly
  assign adj       = (digit >= dcf_pkg::DIGIT_W'(5)) ? digit + dcf_pkg::DIGIT_W'(3) : digit;
  assign carry_out = adj[dcf_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.dabble) begin
      digit <= {adj[dcf_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

FILE: design/decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// decimal_ascii_formatter : 32-bit unsigned to decimal ASCII digits
// Row of BCD cells converts by double dabble, then streams the digits out
// most significant first without leading zeros.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                    | tlast
//  --------+-----+--------------------------+----------------------------
//  s_*     | in  | [31:0] number            | -
//  m_*     | out | [5:0] digit_char, [7:6] 0| last_digit (least sig. digit)
//
//  One request at a time. The request is accepted, then converted one
//  input bit per cycle through the cell chain; trimming then drops the
//  leading digits one at a time and the remaining characters are
//  emitted, ten dropped and emitted digits in all (the chain depth).
//  rst (synchronous) returns the sequencer to idle and empties the output.
//  m_tready low holds a full output register and pauses emit shifting;
//  the final character can wait while the next request is accepted.
//
module decimal_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic        m_tlast    // last_digit
);

  typedef enum logic [1:0] {IDLE, CONVERT, TRIM, EMIT} state_t;

  state_t                          state;
  logic [dcf_pkg::IN_W-1:0]        bin;        // binary shift register
  logic [dcf_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [dcf_pkg::LEFT_W-1:0]      left;       // digits still in the chain
  logic [dcf_pkg::CHAR_W-1:0]      char_q;
  logic                            last_q;

  dcf_pkg::cell_ctl_t              ctl;
  logic [dcf_pkg::DIGIT_W-1:0]     digits [dcf_pkg::NUM_CELLS];
  logic                            carry  [dcf_pkg::NUM_CELLS];
  logic [dcf_pkg::DIGIT_W-1:0]     top;

  logic s_fire, out_free, trim_drop, emit_fire;

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign top      = digits[dcf_pkg::NUM_CELLS-1];

  // drop digits above the kept count, then leading zeros (keep at least one)
  assign trim_drop = (state == TRIM) &&
                     ((int'(left) > dcf_pkg::KEEP) ||
                      (top == '0 && left > dcf_pkg::LEFT_W'(1)));
  assign emit_fire = (state == EMIT) && out_free;

  assign ctl.clear  = s_fire;
  assign ctl.dabble = (state == CONVERT);
  assign ctl.shift  = trim_drop || emit_fire;

  // cell 0 sits at the least significant digit; digits move toward the top
  for (genvar i = 0; i < dcf_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_lsd
      dcf_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (bin[dcf_pkg::IN_W-1]),
        .digit_in  ('0),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end else begin : g_up
      dcf_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i-1]),
        .digit_in  (digits[i-1]),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      bit_cnt  <= '0;
      left     <= '0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_fire) begin
            bin     <= s_tdata;
            bit_cnt <= '0;
            state   <= CONVERT;
          end
        end
        CONVERT: begin
          bin     <= bin << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == dcf_pkg::BIT_CNT_W'(dcf_pkg::IN_W - 1)) begin
            left  <= dcf_pkg::LEFT_W'(dcf_pkg::NUM_CELLS);
            state <= TRIM;
          end
        end
        TRIM: begin
          if (trim_drop) begin
            left <= left - 1'b1;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (emit_fire) begin
            char_q   <= dcf_pkg::ASCII_ZERO + dcf_pkg::CHAR_W'(top);
            last_q   <= (left == dcf_pkg::LEFT_W'(1));
            m_tvalid <= 1'b1;
            left     <= left - 1'b1;
            if (left == dcf_pkg::LEFT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {2'b00, char_q};
  assign m_tlast = last_q;

endmodule

FILE: design/dcf_checker.sv
// ----------------------------------------------------------------------------
// dcf_checker : port-level checks for decimal_ascii_formatter
// Output stability, digit range, one request at a time, no leading zero.
// ----------------------------------------------------------------------------
module dcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  logic first;  // next output character opens a number

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      first <= m_tlast;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata >= 8'd48 && m_tdata <= 8'd57)
    else $error("output is not a decimal digit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken during conversion");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && first && !m_tlast |-> m_tdata != 8'd48)
    else $error("leading zero emitted");

endmodule

bind decimal_ascii_formatter dcf_checker u_dcf_checker (.*);

FILE: tb/tb_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_decimal_ascii_formatter : self-checking bench for the decimal formatter
// Feeds 32-bit numbers, predicts the ASCII digit string of each one and
// compares every emitted character and its last-digit flag in order, with
// random gaps on both streams and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_decimal_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_BUF    = 20;
  localparam int KEEP_LIM     = (dcf_pkg::MAX_DIGITS < 1) ? 1 :
                                (dcf_pkg::MAX_DIGITS > DIGIT_BUF) ? DIGIT_BUF :
                                dcf_pkg::MAX_DIGITS;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_AT_CHAR = 400;   // output stalls after this many chars
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [dcf_pkg::CHAR_W-1:0] code;
    logic                       last;
  } digit_t;

  // expected character stream, built per accepted request
  class decimal_digit_board;
    digit_t pending_chars[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_number(logic [31:0] number);
      logic [dcf_pkg::DIGIT_W-1:0] digs[DIGIT_BUF];
      logic [31:0]                 v;
      int                          cnt;
      int                          keep;
      int                          pos;
      digit_t                      d;
      v   = number;
      cnt = 0;
      // least significant first; zero still gives one digit
      do begin
        digs[cnt] = dcf_pkg::DIGIT_W'(v % 10);
        v         = v / 10;
        cnt++;
      end while (v != 0 && cnt < DIGIT_BUF);
      keep = (cnt > KEEP_LIM) ? KEEP_LIM : cnt;
      for (int k = 0; k < keep; k++) begin
        pos    = keep - 1 - k;
        d.code = dcf_pkg::ASCII_ZERO + dcf_pkg::CHAR_W'(digs[pos]);
        d.last = (pos == 0);
        pending_chars.push_back(d);
      end
    endfunction

    function void check_char(logic [7:0] tdata, logic tlast);
      digit_t exp_d;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual data %h last %b",
                 $time, tdata, tlast);
        mismatches++;
        return;
      end
      exp_d = pending_chars.pop_front();
      if (tdata[dcf_pkg::CHAR_W-1:0] !== exp_d.code) begin
        $display("%0t: digit_char mismatch: expected %0d actual %0d",
                 $time, exp_d.code, tdata[dcf_pkg::CHAR_W-1:0]);
        mismatches++;
      end
      if (tdata[7:dcf_pkg::CHAR_W] !== '0) begin
        $display("%0t: tdata pad mismatch: expected 0 actual %b",
                 $time, tdata[7:dcf_pkg::CHAR_W]);
        mismatches++;
      end
      if (tlast !== exp_d.last) begin
        $display("%0t: last_digit mismatch: expected %b actual %b",
                 $time, exp_d.last, tlast);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  decimal_digit_board board = new();

  decimal_ascii_formatter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // gap per item: random when not calm; calm stretches never idle
  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_number(input logic [31:0] number, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= number;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_number(number);
    @(negedge clk);
  endtask

  // mix of digit lengths so short and full-width strings both show up
  function automatic logic [31:0] pick_number();
    int     len;
    longint lo;
    longint hi;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h1 << $urandom_range(0, 31);
      2: return ~(32'h1 << $urandom_range(0, 31));
      default: begin
        len = $urandom_range(1, 10);
        lo  = (len == 1) ? 0 : 1;
        for (int i = 1; i < len; i++) lo = lo * 10;
        hi  = (len == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
      end
    endcase
  endfunction

  // Output side: random ready gaps plus one long hold so the block backs up.
  initial begin
    int  seen;
    int  wait_cycles;
    bit  calm;
    seen = 0;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (seen % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_cycles = draw_gap(calm);
      if (seen == HOLD_AT_CHAR) wait_cycles += HOLD_CYCLES;
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_char(m_tdata, m_tlast);
      seen++;
      @(negedge clk);
    end
  end

  // Input side: directed corners first, then random numbers.
  initial begin
    logic [31:0] corner[$];
    bit          calm;
    int          drain;
    corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
               32'd1000, 32'd99999, 32'd100000, 32'd9999999, 32'd10000000,
               32'd999999999, 32'd1000000000, 32'd1234567890, 32'd4000000000,
               32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
               32'hFFFF_FFFF, 32'd0};
    calm = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner[i]) send_number(corner[i], draw_gap(1'b0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) calm = ($urandom_range(0, 2) == 0);
      send_number(pick_number(), draw_gap(calm));
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    // let any stray character surface before judging
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    if (board.pending() != 0) begin
      $display("%0t: %0d expected chars never arrived", $time, board.pending());
      board.mismatches++;
    end

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
